// ===== rtl/ptsrch_pkg.sv =====
// ----------------------------------------------------------------------------
// ptsrch_pkg
// Shared sizes, codes and the per-pixel entry layout of the trim search.
// ----------------------------------------------------------------------------
package ptsrch_pkg;

	localparam int NUM_PIXELS = 131072;
	localparam int TRIM_BITS  = 7;
	localparam int ADDR_W     = (NUM_PIXELS > 1) ? $clog2(NUM_PIXELS) : 1;

	localparam int PIX_W      = 17;
	localparam int OCC_W      = 17;
	localparam int OUT_TRIM_W = 7;
	localparam int RANGE_W    = 7;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 17;

	typedef logic [TRIM_BITS-1:0] trim_t;
	typedef logic [OCC_W-1:0]     occ_t;
	typedef logic [ADDR_W-1:0]    addr_t;

	typedef enum logic {
		ACT_START   = 1'b0,
		ACT_MEASURE = 1'b1
	} action_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TARGET = 2'd0,
		CFG_RANGE  = 2'd1
	} cfg_idx_t;

	typedef struct packed {
		trim_t low;
		trim_t high;
		trim_t trial;
		trim_t best;
		occ_t  best_occ;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic   start;
		trim_t  range_top;
		trim_t  init;
		occ_t   occ;
		occ_t   target;
	} upd_ctl_t;

endpackage

// ===== rtl/ptsrch_ram.sv =====
// ----------------------------------------------------------------------------
// ptsrch_ram
// Generic single-write, single-read synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module ptsrch_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/ptsrch_update.sv =====
// ----------------------------------------------------------------------------
// ptsrch_update
// Next-state logic for one pixel entry: start load or one search step.
// ----------------------------------------------------------------------------
module ptsrch_update (
	input  ptsrch_pkg::upd_ctl_t ctl,
	input  ptsrch_pkg::entry_t   cur,
	output ptsrch_pkg::entry_t   nxt
);

	ptsrch_pkg::occ_t        d_new;
	ptsrch_pkg::occ_t        d_best;
	logic                    take;
	logic                    below;
	ptsrch_pkg::trim_t       lo;
	ptsrch_pkg::trim_t       hi;
	logic [ptsrch_pkg::TRIM_BITS:0] sum;

	always_comb begin
		d_new  = (ctl.occ >= ctl.target) ? (ctl.occ - ctl.target) : (ctl.target - ctl.occ);
		d_best = (cur.best_occ >= ctl.target) ? (cur.best_occ - ctl.target)
		                                      : (ctl.target - cur.best_occ);
		take   = (d_new <= d_best);
		below  = (ctl.occ < ctl.target);
		lo     = below ? cur.trial : cur.low;
		hi     = below ? cur.high : cur.trial;
		sum    = {1'b0, lo} + {1'b0, hi};

		if (ctl.start) begin
			nxt.low      = '0;
			nxt.high     = ctl.range_top;
			nxt.trial    = ctl.init;
			nxt.best     = '0;
			nxt.best_occ = '0;
		end else begin
			nxt.low      = lo;
			nxt.high     = hi;
			nxt.trial    = sum[ptsrch_pkg::TRIM_BITS:1];
			nxt.best     = take ? cur.trial : cur.best;
			nxt.best_occ = take ? ctl.occ : cur.best_occ;
		end
	end

endmodule

// ===== rtl/per_pixel_binary_trim_search.sv =====
// ----------------------------------------------------------------------------
// per_pixel_binary_trim_search
// Per-pixel successive-approximation search for the trim value whose
// measured occupancy lies closest to a target.
// ----------------------------------------------------------------------------
// The block takes one item in every clock cycle while busy is low and
// returns exactly one result for each, marked by a one-cycle done strobe;
// results cannot be held off, so the receiver must take each one as it
// appears. The per-pixel state memory sets the rate of one item per cycle:
// an item reads its entry in the cycle it is taken, the entry is updated
// and written back in the following cycle, and the result register
// captures the updated entry at the end of that cycle.
// Items for the same pixel may follow each other in consecutive cycles; the
// entry just written is forwarded to the next item. Busy is high only in the
// first cycle after reset. The memory has no clearing pass: a pixel must be
// started before it is measured, and a measure of a pixel that was never
// started returns undefined values. Configuration should be written only
// while no item is in flight.
module per_pixel_binary_trim_search (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// Configuration port
	input  logic                                 cfg_we,
	input  logic [ptsrch_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ptsrch_pkg::CFG_DATA_W-1:0]    cfg_data,
	// Item input
	input  logic                                 start,
	output logic                                 busy,
	input  logic                                 action,
	input  logic [ptsrch_pkg::PIX_W-1:0]         pixel_index,
	input  logic [ptsrch_pkg::OUT_TRIM_W-1:0]    initial_trim,
	input  logic [ptsrch_pkg::OCC_W-1:0]         occupancy,
	// Result output
	output logic                                 done,
	output logic [ptsrch_pkg::PIX_W-1:0]         out_pixel,
	output logic [ptsrch_pkg::OUT_TRIM_W-1:0]    next_trim,
	output logic [ptsrch_pkg::OUT_TRIM_W-1:0]    best_trim,
	output logic [ptsrch_pkg::OCC_W-1:0]         best_occupancy
);

	// Configuration registers.
	ptsrch_pkg::occ_t                  target_q;
	logic [ptsrch_pkg::RANGE_W-1:0]    range_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= ptsrch_pkg::occ_t'(65536);
			range_q  <= ptsrch_pkg::RANGE_W'(32);
		end else if (cfg_we) begin
			unique case (ptsrch_pkg::cfg_idx_t'(cfg_index))
				ptsrch_pkg::CFG_TARGET: target_q <= cfg_data;
				ptsrch_pkg::CFG_RANGE:  range_q  <= cfg_data[ptsrch_pkg::RANGE_W-1:0];
				default: ;
			endcase
		end
	end

	// Busy is held for one cycle after reset so the first item meets a
	// settled pipeline; after that an item can be taken in every cycle.
	logic busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
		end else begin
			busy_q <= 1'b0;
		end
	end

	assign busy = busy_q;

	logic accept;
	assign accept = start && !busy_q;

	// Address decode. Pixels beyond the array change nothing and answer zero.
	logic [31:0]         pix_wide;
	logic                in_range;
	ptsrch_pkg::addr_t   rd_addr;

	assign pix_wide = 32'(pixel_index);
	assign in_range = (pix_wide < 32'(ptsrch_pkg::NUM_PIXELS));
	assign rd_addr  = pix_wide[ptsrch_pkg::ADDR_W-1:0];

	// Stage 1: the entry read is in flight; the item fields wait alongside.
	logic                           vld_s1;
	logic                           start_s1;
	logic                           in_range_s1;
	logic [ptsrch_pkg::PIX_W-1:0]   pix_s1;
	ptsrch_pkg::addr_t              addr_s1;
	ptsrch_pkg::trim_t              init_s1;
	ptsrch_pkg::occ_t               occ_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			start_s1    <= (ptsrch_pkg::action_t'(action) == ptsrch_pkg::ACT_START);
			in_range_s1 <= in_range;
			pix_s1      <= pixel_index;
			addr_s1     <= rd_addr;
			init_s1     <= ptsrch_pkg::trim_t'(initial_trim);
			occ_s1      <= occupancy;
		end
	end

	// State memory and the record of the last write, used to forward an
	// entry to an item of the same pixel that read it before the write took effect.
	logic [ptsrch_pkg::ENTRY_W-1:0] rd_data;
	ptsrch_pkg::entry_t             cur_entry;
	ptsrch_pkg::entry_t             nxt_entry;
	logic                           wr_en;
	logic                           last_wr_q;
	ptsrch_pkg::addr_t              last_addr_q;
	ptsrch_pkg::entry_t             last_data_q;

	assign wr_en = vld_s1 && in_range_s1;

	ptsrch_ram #(
		.WIDTH (ptsrch_pkg::ENTRY_W),
		.DEPTH (ptsrch_pkg::NUM_PIXELS)
	) u_state_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (addr_s1),
		.wdata (nxt_entry),
		.re    (accept),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_wr_q <= 1'b0;
		end else begin
			last_wr_q <= wr_en;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			last_addr_q <= addr_s1;
			last_data_q <= nxt_entry;
		end
	end

	assign cur_entry = (last_wr_q && (last_addr_q == addr_s1)) ? last_data_q
	                                                          : ptsrch_pkg::entry_t'(rd_data);

	// Entry update.
	ptsrch_pkg::upd_ctl_t upd_ctl;

	always_comb begin
		upd_ctl.start     = start_s1;
		upd_ctl.range_top = ptsrch_pkg::trim_t'(range_q);
		upd_ctl.init      = init_s1;
		upd_ctl.occ       = occ_s1;
		upd_ctl.target    = target_q;
	end

	ptsrch_update u_update (
		.ctl (upd_ctl),
		.cur (cur_entry),
		.nxt (nxt_entry)
	);

	// Result register.
	logic                                 done_q;
	logic [ptsrch_pkg::PIX_W-1:0]         out_pixel_q;
	logic [ptsrch_pkg::OUT_TRIM_W-1:0]    next_trim_q;
	logic [ptsrch_pkg::OUT_TRIM_W-1:0]    best_trim_q;
	ptsrch_pkg::occ_t                     best_occ_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			out_pixel_q <= pix_s1;
			if (in_range_s1) begin
				next_trim_q <= ptsrch_pkg::OUT_TRIM_W'(nxt_entry.trial);
				best_trim_q <= ptsrch_pkg::OUT_TRIM_W'(nxt_entry.best);
				best_occ_q  <= nxt_entry.best_occ;
			end else begin
				next_trim_q <= '0;
				best_trim_q <= '0;
				best_occ_q  <= '0;
			end
		end
	end

	assign done           = done_q;
	assign out_pixel      = out_pixel_q;
	assign next_trim      = next_trim_q;
	assign best_trim      = best_trim_q;
	assign best_occupancy = best_occ_q;

endmodule

// ===== rtl/ptsrch_checker.sv =====
// ----------------------------------------------------------------------------
// ptsrch_checker
// Port-level checks of the trim search: result timing and start results.
// ----------------------------------------------------------------------------
module ptsrch_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 start,
	input logic                                 busy,
	input logic                                 action,
	input logic [ptsrch_pkg::PIX_W-1:0]         pixel_index,
	input logic [ptsrch_pkg::OUT_TRIM_W-1:0]    initial_trim,
	input logic                                 done,
	input logic [ptsrch_pkg::PIX_W-1:0]         out_pixel,
	input logic [ptsrch_pkg::OUT_TRIM_W-1:0]    next_trim,
	input logic [ptsrch_pkg::OUT_TRIM_W-1:0]    best_trim,
	input logic [ptsrch_pkg::OCC_W-1:0]         best_occupancy
);

	logic acc;
	logic acc_start;
	logic [31:0] pix_wide;

	assign acc       = start && !busy;
	assign acc_start = acc && (ptsrch_pkg::action_t'(action) == ptsrch_pkg::ACT_START);
	assign pix_wide  = 32'(pixel_index);

	// Every taken item gives exactly one result, and no result appears without one.
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		done == $past(acc, 2))
		else $error("result strobe does not follow taken item");

	a_pixel_order: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (out_pixel == $past(pixel_index, 2)))
		else $error("result pixel does not match item pixel");

	a_start_best: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(acc_start, 2)) |-> (best_trim == '0 && best_occupancy == '0))
		else $error("start result carries a non-zero best");

	a_start_trial: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(acc_start && (pix_wide < 32'(ptsrch_pkg::NUM_PIXELS)), 2)) |->
		(next_trim == ptsrch_pkg::OUT_TRIM_W'(ptsrch_pkg::trim_t'($past(initial_trim, 2)))))
		else $error("start result does not return the initial trim");

endmodule

bind per_pixel_binary_trim_search ptsrch_checker u_ptsrch_checker (.*);
